FILE: sv/bffa_pkg.sv
// Shared constants, types and helper functions for the first-fit bitmap allocator.
package bffa_pkg;

  localparam int MAP_BITS   = 4096;
  localparam int WORD_BITS  = 64;   // power of two, 8..64
  localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = $clog2(MAP_BITS + 1);
  localparam int TAIL_BITS  = MAP_BITS - (WORD_COUNT - 1) * WORD_BITS;

  // Payload field widths
  localparam int IDX_W   = 12;
  localparam int GRANT_W = 12;
  localparam int USED_W  = 13;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_first;   // start of scan: read word 0
    logic rd_next;    // scan on: read the following word
    logic rd_free;    // read the word holding the item's index
    logic fin_alloc;  // set the found bit, post result
    logic fin_fail;   // map full, post failure
    logic fin_free;   // clear the named bit, post result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic has_zero;   // scanned word holds a clear bit
    logic last_word;  // scanned word is the last of the map
  } st_t;

  // Bits past MAP_BITS in the last word read as set so a scan never grants them
  function automatic word_t tail_pad();
    word_t p;
    p = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (i >= TAIL_BITS) p[i] = 1'b1;
    end
    return p;
  endfunction

  // Position of the lowest clear bit: isolate it as one-hot, then encode
  function automatic logic [BIT_W-1:0] lowest_zero(word_t w);
    word_t z;
    word_t oh;
    logic [BIT_W-1:0] p;
    z  = ~w;
    oh = z & (~z + word_t'(1));
    p  = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) p = p | BIT_W'(i);
    end
    return p;
  endfunction

  function automatic logic [ADDR_W-1:0] word_of(logic [IDX_W-1:0] idx);
    return ADDR_W'(idx >> BIT_W);
  endfunction

endpackage

FILE: sv/bffa_if.sv
// Request and result channel interfaces of the bitmap allocator.
interface bffa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [bffa_pkg::IDX_W-1:0] index;

  modport source (output valid, mode, index, input ready);
  modport sink   (input valid, mode, index, output ready);
endinterface

interface bffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [bffa_pkg::GRANT_W-1:0] granted;
  logic [bffa_pkg::USED_W-1:0]  used_count;

  modport source (output valid, ok, granted, used_count, input ready);
  modport sink   (input valid, ok, granted, used_count, output ready);
endinterface

FILE: sv/bffa_datapath.sv
// Bitmap word store, scan address, set-bit counter and result register.
module bffa_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bffa_pkg::cmd_t               cmd,
  input  logic [bffa_pkg::IDX_W-1:0]   in_index,
  output bffa_pkg::st_t                st,
  output logic                         res_ok,
  output logic [bffa_pkg::GRANT_W-1:0] res_granted,
  output logic [bffa_pkg::USED_W-1:0]  res_used
);

  localparam bffa_pkg::word_t TAIL_PAD = bffa_pkg::tail_pad();
  localparam logic [bffa_pkg::ADDR_W-1:0] LAST_ADDR =
    bffa_pkg::ADDR_W'(bffa_pkg::WORD_COUNT - 1);

  bffa_pkg::word_t mem [bffa_pkg::WORD_COUNT];
  logic [bffa_pkg::WORD_COUNT-1:0] vld_r;   // word written since reset

  bffa_pkg::word_t                rdata_r;
  logic                           rvld_r;
  logic [bffa_pkg::ADDR_W-1:0]    chk_addr_r, chk_addr_nxt;
  logic [bffa_pkg::IDX_W-1:0]     idx_r;
  logic [bffa_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           res_ok_r;
  logic [bffa_pkg::GRANT_W-1:0]   res_granted_r;
  logic [bffa_pkg::USED_W-1:0]    res_used_r;

  logic                           rd_en;
  logic [bffa_pkg::ADDR_W-1:0]    rd_addr;
  logic                           we;
  logic [bffa_pkg::ADDR_W-1:0]    wa;
  bffa_pkg::word_t                wd;
  bffa_pkg::word_t                raw;
  bffa_pkg::word_t                scan_word;
  logic [bffa_pkg::BIT_W-1:0]     zero_pos;
  logic [bffa_pkg::BIT_W-1:0]     free_pos;
  logic                           in_range;
  logic                           bit_set;

  assign raw       = rvld_r ? rdata_r : '0;
  assign scan_word = raw | ((chk_addr_r == LAST_ADDR) ? TAIL_PAD : '0);
  assign zero_pos  = bffa_pkg::lowest_zero(scan_word);
  assign free_pos  = idx_r[bffa_pkg::BIT_W-1:0];
  assign in_range  = (32'(idx_r) < 32'(bffa_pkg::MAP_BITS));
  assign bit_set   = raw[free_pos];

  assign st.has_zero  = ~&scan_word;
  assign st.last_word = (chk_addr_r == LAST_ADDR);

  assign rd_en = cmd.rd_first | cmd.rd_next | cmd.rd_free;

  always_comb begin
    chk_addr_nxt = chk_addr_r;
    rd_addr      = bffa_pkg::word_of(in_index);
    if (cmd.rd_first) begin
      chk_addr_nxt = '0;
      rd_addr      = '0;
    end else if (cmd.rd_next) begin
      chk_addr_nxt = chk_addr_r + 1'b1;
      rd_addr      = chk_addr_r + 1'b1;
    end
  end

  always_comb begin
    we      = 1'b0;
    wa      = chk_addr_r;
    wd      = raw;
    cnt_nxt = cnt_r;
    if (cmd.fin_alloc) begin
      we      = 1'b1;
      wd      = raw | (bffa_pkg::word_t'(1) << zero_pos);
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.fin_free && in_range) begin
      we = 1'b1;
      wa = bffa_pkg::word_of(idx_r);
      wd = raw & ~(bffa_pkg::word_t'(1) << free_pos);
      if (bit_set) cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Word store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
    end else begin
      if (we) vld_r[wa] <= 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    if (cmd.rd_free) idx_r <= in_index;
    if (cmd.fin_alloc | cmd.fin_fail | cmd.fin_free) begin
      res_ok_r      <= cmd.fin_alloc | (cmd.fin_free & in_range);
      res_granted_r <= cmd.fin_alloc ?
                       bffa_pkg::GRANT_W'({chk_addr_r, zero_pos}) : '0;
      res_used_r    <= bffa_pkg::USED_W'(cnt_nxt);
    end
  end

  assign res_ok      = res_ok_r;
  assign res_granted = res_granted_r;
  assign res_used    = res_used_r;

  a_fail_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_fail |-> cnt_r == bffa_pkg::CNT_W'(bffa_pkg::MAP_BITS))
    else $error("allocation failed with free bits left");

  a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_alloc |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count not raised by allocation");

  a_bad_free_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_free && !in_range) |=> $stable(cnt_r))
    else $error("out of range free changed the count");

endmodule

FILE: sv/bffa_ctrl.sv
// Sequencer for allocate scans and frees, and result valid.
module bffa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_mode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bffa_pkg::st_t  st,
  output bffa_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   fin;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;
  assign fin       = cmd.fin_alloc | cmd.fin_fail | cmd.fin_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == bffa_pkg::MODE_FREE) begin
            cmd.rd_free = 1'b1;
            state_nxt   = S_FREE;
          end else begin
            cmd.rd_first = 1'b1;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        priority if (st.has_zero) begin
          if (slot_free) begin
            cmd.fin_alloc = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (st.last_word) begin
          if (slot_free) begin
            cmd.fin_fail = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_FREE: begin
        if (slot_free) begin
          cmd.fin_free = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = fin ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fin_alloc, cmd.fin_fail, cmd.fin_free}))
    else $error("more than one finish command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_next |-> (!st.has_zero && !st.last_word))
    else $error("scan stepped past a usable or final word");

endmodule

FILE: sv/bitmap_first_free_allocator_core.sv
// Top level of the first-fit bitmap allocator: sequencer plus bitmap datapath.
//
//  channel  dir  handshake         payload
//  in_ch    in   valid/ready       mode (0 alloc, 1 free), index[11:0]
//  out_ch   out  valid/ready       ok, granted[11:0], used_count[12:0]
//
// Allocate: a start step reads word 0, then one bitmap word a cycle until a clear bit
// is found, up to WORD_COUNT words (64 with a 64-bit word), through the single read
// port of the word store. Free: a read of the indexed word, then its write back.
// Reset clears the map at once through per-word written flags; no sweep.
// One item in flight; a new item is taken while the last result still waits.
// A stalled result holds the finishing step until the output register frees.
module bitmap_first_free_allocator_core (
  input  logic         clk,
  input  logic         rst_n,
  bffa_req_if.sink     in_ch,
  bffa_rsp_if.source   out_ch
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::st_t  st;

  // sequencer: decides which word to read and when an item finishes
  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // bitmap store, counter and result payload
  bffa_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_index    (in_ch.index),
    .st          (st),
    .res_ok      (out_ch.ok),
    .res_granted (out_ch.granted),
    .res_used    (out_ch.used_count)
  );

endmodule
